// File: rtl/rip_pkg.sv
// Shared constants, codes and controller/datapath interface types of the raster interpolator.
package rip_pkg;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int COL_AW   = $clog2(MAX_COLS);
  localparam int ADDR_W   = $clog2(MAX_ROWS * MAX_COLS);
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;

  localparam int DIM_W  = 9;
  localparam int IDX_W  = DIM_W + 2;
  localparam int CRD_W  = 40;
  localparam int CS_W   = 21;
  localparam int OFS_W  = 25;
  localparam int D2_W   = 48;
  localparam int WGT_W  = 51;
  localparam int ACC_W  = 85;
  localparam int SUM_W  = 53;
  localparam int QUO_W  = 64;
  localparam int CNT_W  = 7;
  localparam int CIDX_W = 3;

  localparam logic [CS_W-1:0] CS_RESET = CS_W'(256000);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_OFFGRID = 2'd2;

  typedef enum logic [CIDX_W-1:0] {
    CFG_NUM_ROWS  = 3'd0,
    CFG_NUM_COLS  = 3'd1,
    CFG_ORIGIN_X  = 3'd2,
    CFG_ORIGIN_Y  = 3'd3,
    CFG_CELL_SIZE = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_B_MX, S_B_MY, S_B_HY, S_B_CHK,
    S_DX_GO, S_DX_W, S_DY_GO, S_DY_W,
    S_G_MX, S_G_MY, S_G_DY, S_CORN,
    S_C_RD, S_C_SQY, S_C_D2, S_W_GO, S_W_W,
    S_M_LO, S_M_HI, S_M_ADD, S_F_GO, S_F_W
  } state_e;

  typedef enum logic [2:0] {
    MUL_HIX, MUL_HIY, MUL_GX, MUL_GY, MUL_SQX, MUL_SQY, MUL_WLO, MUL_WHI
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_X, DIV_Y, DIV_WGT, DIV_FINAL
  } div_sel_e;

  typedef enum logic [2:0] {
    EMIT_NONE, EMIT_WRITE, EMIT_OUTSIDE, EMIT_OFFGRID, EMIT_EXACT, EMIT_MEAN
  } emit_e;

  typedef struct packed {
    logic     load;
    logic     ram_we;
    mul_sel_e mul_sel;
    logic     cap_hix;
    logic     cap_hiy;
    logic     div_start;
    div_sel_e div_sel;
    logic     cap_col;
    logic     cap_row;
    logic     cap_dx;
    logic     cap_dy;
    logic     cap_sqx;
    logic     cap_d2;
    logic     cap_w;
    logic     acc_lo;
    logic     acc_hi;
    emit_e    emit;
  } cmd_t;

  typedef struct packed {
    logic outside;
    logic off_grid;
    logic d2_zero;
    logic div_done;
    logic last_k;
  } sts_t;

endpackage

// File: rtl/raster_idw_point_interpolator.sv
// Top level of the raster point interpolator with inverse-distance weighting.
//
// An item is taken at a clock edge where start is high and busy is low.
// req_type_i low writes cell_value_i to the cell at cell_row_i/cell_col_i;
// high asks for the value at query_x_i/query_y_i (Q24.8).
// Each item yields one result beat: done_o is high for exactly one cycle
// with status_o, interp_value_o, base_row_o and base_col_o. The receiver
// cannot stall, so the beat must be taken when it appears.
// A write returns its beat in the cycle after acceptance, and writes may
// follow each other in every cycle. A query outside the raster returns after
// states S_B_MX, S_B_MY, S_B_HY and S_B_CHK; a full query is paced by the
// shared divider that retires one quotient bit per cycle over two index
// divisions, four weight divisions and the final 85-bit mean division.
// The user writes registers through cfg_we_i, cfg_idx_i and cfg_wdata_i only
// while busy is low and no result is pending; the block does not enforce this.
// Reset clears the controller and restores register defaults; the cell memory
// holds no defined value until each cell is written.
module raster_idw_point_interpolator import rip_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              req_type_i,
  input  logic [7:0]        cell_row_i,
  input  logic [7:0]        cell_col_i,
  input  logic [31:0]       cell_value_i,
  input  logic [31:0]       query_x_i,
  input  logic [31:0]       query_y_i,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [31:0]       interp_value_o,
  output logic [7:0]        base_row_o,
  output logic [7:0]        base_col_o
);

  cmd_t cmd;
  sts_t sts;

  rip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .busy       (busy),
    .cmd_o      (cmd)
  );

  rip_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cell_row_i     (cell_row_i),
    .cell_col_i     (cell_col_i),
    .cell_value_i   (cell_value_i),
    .query_x_i      (query_x_i),
    .query_y_i      (query_y_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .interp_value_o (interp_value_o),
    .base_row_o     (base_row_o),
    .base_col_o     (base_col_o)
  );

endmodule

// File: rtl/rip_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rip_div.sv
// Shared restoring divider that retires one quotient bit per cycle.
module rip_div import rip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ACC_W-1:0] numer_i,
  input  logic [SUM_W-1:0] denom_i,
  input  logic [CNT_W-1:0] count_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0] num_q, num_d;
  logic [SUM_W-1:0] den_q, den_d, rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [SUM_W:0]   trial;
  logic             qbit;

  always_comb begin
    trial  = {rem_q, num_q[ACC_W-1]};
    qbit   = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = count_i;
      num_d  = numer_i;
      den_d  = denom_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = qbit ? SUM_W'(trial - {1'b0, den_q}) : trial[SUM_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], qbit};
      num_d = {num_q[ACC_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/rip_datapath.sv
// Datapath: configuration registers, cell memory, multiplier, divider and result registers.
module rip_datapath import rip_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic [7:0]        cell_row_i,
  input  logic [7:0]        cell_col_i,
  input  logic [31:0]       cell_value_i,
  input  logic [31:0]       query_x_i,
  input  logic [31:0]       query_y_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [31:0]       interp_value_o,
  output logic [7:0]        base_row_o,
  output logic [7:0]        base_col_o
);

  logic [DIM_W-1:0]  num_rows_q, num_cols_q;
  logic [31:0]       origin_x_q, origin_y_q;
  logic [CS_W-1:0]   cell_size_q;

  logic [DIM_W-1:0]  nr, nc;
  logic [CS_W-1:0]   cs;
  logic signed [CRD_W-1:0] ox2, oy2, lox, loy, csx;

  logic signed [CRD_W-1:0] x2_q, y2_q, lox_q, loy_q, hix_q, hiy_q;
  logic [DIM_W-1:0]  row_q, col_q;
  logic signed [OFS_W-1:0] dx_q, dy_q;
  logic [1:0]        k_q;
  logic [31:0]       val_q;
  logic [D2_W-1:0]   sqx_q, d2_q, d2;
  logic [WGT_W-1:0]  w_q;
  logic [ACC_W-1:0]  acc_q;
  logic [SUM_W-1:0]  bsum_q;
  logic [63:0]       prod_q;
  logic [31:0]       mul_a, mul_b;

  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [31:0]       interp_q;
  logic [7:0]        brow_q, bcol_q;

  logic [ACC_W-1:0]  div_numer;
  logic [SUM_W-1:0]  div_denom;
  logic [CNT_W-1:0]  div_count;
  logic              div_busy, div_done;
  logic [QUO_W-1:0]  div_quo;

  logic signed [CRD_W-1:0] diff_x, diff_y, dxw, dyw;
  logic signed [IDX_W-1:0] row_s, col_s, nr_s, nc_s, rowt, top, bot, left, right, rr, cc;
  logic [DIM_W-1:0]  qx, qy;
  logic signed [OFS_W-1:0] cs2, ex, ey;
  logic [OFS_W-1:0]  abs_ex, abs_ey;
  logic [31:0]       val_x, rdata;
  logic [ADDR_W-1:0] waddr, raddr;
  logic              wr_ok;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q  <= '0;
      num_cols_q  <= '0;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      cell_size_q <= CS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_ROWS:  num_rows_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_NUM_COLS:  num_cols_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_ORIGIN_X:  origin_x_q  <= cfg_wdata_i;
        CFG_ORIGIN_Y:  origin_y_q  <= cfg_wdata_i;
        CFG_CELL_SIZE: cell_size_q <= cfg_wdata_i[CS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nr  = (int'(num_rows_q) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : num_rows_q;
    nc  = (int'(num_cols_q) > MAX_COLS) ? DIM_W'(MAX_COLS) : num_cols_q;
    cs  = (cell_size_q == '0) ? CS_W'(1) : cell_size_q;
    csx = $signed({{(CRD_W-CS_W){1'b0}}, cs});
    ox2 = $signed({{(CRD_W-33){origin_x_q[31]}}, origin_x_q, 1'b0});
    oy2 = $signed({{(CRD_W-33){origin_y_q[31]}}, origin_y_q, 1'b0});
    lox = ox2 + csx;
    loy = oy2 + csx;
  end

  // Cell memory.
  always_comb begin
    wr_ok = (int'(cell_row_i) < MAX_ROWS) && (int'(cell_col_i) < MAX_COLS);
    waddr = ADDR_W'(cell_row_i) * ADDR_W'(MAX_COLS) + ADDR_W'(cell_col_i);
    raddr = ADDR_W'(rr[DIM_W-1:0]) * ADDR_W'(MAX_COLS) + ADDR_W'(cc[DIM_W-1:0]);
  end

  rip_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we && wr_ok),
    .waddr_i (waddr),
    .wdata_i (cell_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Corner geometry.
  always_comb begin
    row_s = $signed({2'b00, row_q});
    col_s = $signed({2'b00, col_q});
    nr_s  = $signed({2'b00, nr});
    nc_s  = $signed({2'b00, nc});
    top   = (dy_q > 0) ? row_s - IDX_W'(1) : row_s;
    bot   = (dy_q < 0) ? row_s + IDX_W'(1) : row_s;
    left  = (dx_q < 0) ? col_s - IDX_W'(1) : col_s;
    right = (dx_q > 0) ? col_s + IDX_W'(1) : col_s;
    cs2   = $signed({{(OFS_W-CS_W-1){1'b0}}, cs, 1'b0});
    if (k_q == 2'd0 || k_q == 2'd3) begin
      rr = top;
      ey = (dy_q > 0) ? cs2 - dy_q : -dy_q;
    end else begin
      rr = bot;
      ey = (dy_q < 0) ? -dy_q - cs2 : -dy_q;
    end
    if (k_q == 2'd0 || k_q == 2'd1) begin
      cc = left;
      ex = (dx_q < 0) ? -dx_q - cs2 : -dx_q;
    end else begin
      cc = right;
      ex = (dx_q > 0) ? cs2 - dx_q : -dx_q;
    end
    abs_ex = ex[OFS_W-1] ? OFS_W'(-ex) : OFS_W'(ex);
    abs_ey = ey[OFS_W-1] ? OFS_W'(-ey) : OFS_W'(ey);
    val_x  = {~val_q[31], val_q[30:0]};
    d2     = sqx_q + prod_q[D2_W-1:0];
  end

  // Shared multiplier.
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_HIX: begin
        mul_a = 32'({nc - DIM_W'(1), 1'b1});
        mul_b = 32'(cs);
      end
      MUL_HIY: begin
        mul_a = 32'({nr - DIM_W'(1), 1'b1});
        mul_b = 32'(cs);
      end
      MUL_GX: begin
        mul_a = 32'({col_q, 1'b1});
        mul_b = 32'(cs);
      end
      MUL_GY: begin
        mul_a = 32'({nr - row_q - DIM_W'(1), 1'b1});
        mul_b = 32'(cs);
      end
      MUL_SQX: begin
        mul_a = 32'(abs_ex);
        mul_b = 32'(abs_ex);
      end
      MUL_SQY: begin
        mul_a = 32'(abs_ey);
        mul_b = 32'(abs_ey);
      end
      MUL_WLO: begin
        mul_a = val_x;
        mul_b = w_q[31:0];
      end
      MUL_WHI: begin
        mul_a = val_x;
        mul_b = 32'(w_q[WGT_W-1:32]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
  end

  // Divider operands.
  always_comb begin
    diff_x = x2_q - lox_q;
    diff_y = y2_q - loy_q;
    unique case (cmd_i.div_sel)
      DIV_X: begin
        div_numer = {diff_x[30:0], {(ACC_W-31){1'b0}}};
        div_denom = SUM_W'({cs, 1'b0});
        div_count = CNT_W'(31);
      end
      DIV_Y: begin
        div_numer = {diff_y[30:0], {(ACC_W-31){1'b0}}};
        div_denom = SUM_W'({cs, 1'b0});
        div_count = CNT_W'(31);
      end
      DIV_WGT: begin
        div_numer = {1'b1, {(ACC_W-1){1'b0}}};
        div_denom = SUM_W'(d2_q);
        div_count = CNT_W'(WGT_W);
      end
      default: begin
        div_numer = acc_q;
        div_denom = bsum_q;
        div_count = CNT_W'(ACC_W);
      end
    endcase
  end

  rip_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .numer_i (div_numer),
    .denom_i (div_denom),
    .count_i (div_count),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    qx   = div_quo[DIM_W-1:0];
    qy   = div_quo[DIM_W-1:0];
    rowt = nr_s - $signed({2'b00, qy}) - IDX_W'(1);
    dxw  = x2_q - (ox2 + $signed({1'b0, prod_q[CRD_W-2:0]}));
    dyw  = y2_q - (oy2 + $signed({1'b0, prod_q[CRD_W-2:0]}));
  end

  // Working registers of a query.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.load) begin
      k_q <= '0;
    end else if (cmd_i.acc_hi) begin
      k_q <= k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x2_q   <= $signed({{(CRD_W-33){query_x_i[31]}}, query_x_i, 1'b0});
      y2_q   <= $signed({{(CRD_W-33){query_y_i[31]}}, query_y_i, 1'b0});
      lox_q  <= lox;
      loy_q  <= loy;
      acc_q  <= '0;
      bsum_q <= '0;
    end
    if (cmd_i.cap_hix) hix_q <= ox2 + $signed({1'b0, prod_q[CRD_W-2:0]});
    if (cmd_i.cap_hiy) hiy_q <= oy2 + $signed({1'b0, prod_q[CRD_W-2:0]});
    if (cmd_i.cap_col) col_q <= (qx >= nc) ? nc - DIM_W'(1) : qx;
    if (cmd_i.cap_row) begin
      if (rowt >= nr_s) begin
        row_q <= nr - DIM_W'(1);
      end else if (rowt < 0) begin
        row_q <= '0;
      end else begin
        row_q <= rowt[DIM_W-1:0];
      end
    end
    if (cmd_i.cap_dx) dx_q <= dxw[OFS_W-1:0];
    if (cmd_i.cap_dy) dy_q <= dyw[OFS_W-1:0];
    if (cmd_i.cap_sqx) begin
      sqx_q <= prod_q[D2_W-1:0];
      val_q <= rdata;
    end
    if (cmd_i.cap_d2) d2_q <= d2;
    if (cmd_i.cap_w) w_q <= div_quo[WGT_W-1:0];
    if (cmd_i.acc_lo) acc_q <= acc_q + ACC_W'(prod_q);
    if (cmd_i.acc_hi) begin
      acc_q  <= acc_q + {prod_q[ACC_W-33:0], 32'd0};
      bsum_q <= bsum_q + SUM_W'(w_q);
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.outside  = (nr == '0) || (nc == '0) || (x2_q < lox_q) || (y2_q < loy_q) ||
                     (x2_q > hix_q) || (y2_q > hiy_q);
    sts_o.off_grid = (top < 0) || (bot >= nr_s) || (left < 0) || (right >= nc_s);
    sts_o.d2_zero  = (d2 == '0);
    sts_o.div_done = div_done;
    sts_o.last_k   = (k_q == 2'd3);
  end

  // Result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (cmd_i.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.emit)
      EMIT_WRITE, EMIT_OUTSIDE: begin
        status_q <= (cmd_i.emit == EMIT_WRITE) ? ST_OK : ST_OUTSIDE;
        interp_q <= '0;
        brow_q   <= '0;
        bcol_q   <= '0;
      end
      EMIT_OFFGRID: begin
        status_q <= ST_OFFGRID;
        interp_q <= '0;
        brow_q   <= row_q[7:0];
        bcol_q   <= col_q[7:0];
      end
      EMIT_EXACT: begin
        status_q <= ST_OK;
        interp_q <= val_q;
        brow_q   <= row_q[7:0];
        bcol_q   <= col_q[7:0];
      end
      EMIT_MEAN: begin
        status_q <= ST_OK;
        interp_q <= {~div_quo[31], div_quo[30:0]};
        brow_q   <= row_q[7:0];
        bcol_q   <= col_q[7:0];
      end
      default: ;
    endcase
  end

  assign done_o         = out_valid_q;
  assign status_o       = status_q;
  assign interp_value_o = interp_q;
  assign base_row_o     = brow_q;
  assign base_col_o     = bcol_q;

`ifndef SYNTHESIS
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy) else $error("Divider started while busy.");
  a_fin_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_start && cmd_i.div_sel == DIV_FINAL) |-> (bsum_q != '0))
    else $error("Final division has a zero weight sum.");
  a_mean_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit == EMIT_MEAN) |-> div_done) else $error("Mean taken before divide done.");
  a_zero_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_OK) |-> (interp_q == '0))
    else $error("Nonzero value with failing status.");
`endif

endmodule

// File: rtl/rip_ctrl.sv
// Controller state machine that sequences the interpolator datapath.
module rip_ctrl import rip_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic req_type_i,
  input  sts_t sts_i,
  output logic busy,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start && req_type_i) state_d = S_B_MX;
      S_B_MX:  state_d = S_B_MY;
      S_B_MY:  state_d = S_B_HY;
      S_B_HY:  state_d = S_B_CHK;
      S_B_CHK: state_d = sts_i.outside ? S_IDLE : S_DX_GO;
      S_DX_GO: state_d = S_DX_W;
      S_DX_W:  if (sts_i.div_done) state_d = S_DY_GO;
      S_DY_GO: state_d = S_DY_W;
      S_DY_W:  if (sts_i.div_done) state_d = S_G_MX;
      S_G_MX:  state_d = S_G_MY;
      S_G_MY:  state_d = S_G_DY;
      S_G_DY:  state_d = S_CORN;
      S_CORN:  state_d = sts_i.off_grid ? S_IDLE : S_C_RD;
      S_C_RD:  state_d = S_C_SQY;
      S_C_SQY: state_d = S_C_D2;
      S_C_D2:  state_d = sts_i.d2_zero ? S_IDLE : S_W_GO;
      S_W_GO:  state_d = S_W_W;
      S_W_W:   if (sts_i.div_done) state_d = S_M_LO;
      S_M_LO:  state_d = S_M_HI;
      S_M_HI:  state_d = S_M_ADD;
      S_M_ADD: state_d = sts_i.last_k ? S_F_GO : S_C_RD;
      S_F_GO:  state_d = S_F_W;
      S_F_W:   if (sts_i.div_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_HIX;
    cmd_o.div_sel = DIV_X;
    cmd_o.emit    = EMIT_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start && req_type_i) begin
          cmd_o.load = 1'b1;
        end else if (start) begin
          cmd_o.ram_we = 1'b1;
          cmd_o.emit   = EMIT_WRITE;
        end
      end
      S_B_MX: cmd_o.mul_sel = MUL_HIX;
      S_B_MY: begin
        cmd_o.mul_sel = MUL_HIY;
        cmd_o.cap_hix = 1'b1;
      end
      S_B_HY: cmd_o.cap_hiy = 1'b1;
      S_B_CHK: if (sts_i.outside) cmd_o.emit = EMIT_OUTSIDE;
      S_DX_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_X;
      end
      S_DX_W: cmd_o.cap_col = sts_i.div_done;
      S_DY_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_Y;
      end
      S_DY_W: cmd_o.cap_row = sts_i.div_done;
      S_G_MX: cmd_o.mul_sel = MUL_GX;
      S_G_MY: begin
        cmd_o.mul_sel = MUL_GY;
        cmd_o.cap_dx  = 1'b1;
      end
      S_G_DY: cmd_o.cap_dy = 1'b1;
      S_CORN: if (sts_i.off_grid) cmd_o.emit = EMIT_OFFGRID;
      S_C_RD: cmd_o.mul_sel = MUL_SQX;
      S_C_SQY: begin
        cmd_o.mul_sel = MUL_SQY;
        cmd_o.cap_sqx = 1'b1;
      end
      S_C_D2: begin
        if (sts_i.d2_zero) begin
          cmd_o.emit = EMIT_EXACT;
        end else begin
          cmd_o.cap_d2 = 1'b1;
        end
      end
      S_W_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_WGT;
      end
      S_W_W: begin
        cmd_o.div_sel = DIV_WGT;
        cmd_o.cap_w   = sts_i.div_done;
      end
      S_M_LO: cmd_o.mul_sel = MUL_WLO;
      S_M_HI: begin
        cmd_o.mul_sel = MUL_WHI;
        cmd_o.acc_lo  = 1'b1;
      end
      S_M_ADD: cmd_o.acc_hi = 1'b1;
      S_F_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_FINAL;
      end
      S_F_W: begin
        cmd_o.div_sel = DIV_FINAL;
        if (sts_i.div_done) cmd_o.emit = EMIT_MEAN;
      end
      default: ;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule
